// ----- hdl/uplink_include_exclude_filter_macros.svh -----
// Assertion macros shared by the uplink filter RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef UPLINK_INCLUDE_EXCLUDE_FILTER_MACROS_SVH
`define UPLINK_INCLUDE_EXCLUDE_FILTER_MACROS_SVH

`ifndef SYNTHESIS
`define UIEF_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define UIEF_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define UIEF_ASSERT(lbl, clk, rst_n, prop, msg)
`define UIEF_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

// ----- hdl/uief_pkg.sv -----
// Types, constants and helpers for the uplink include/exclude filter.
// Used by the top level, the address store and the testbench; depends on nothing.
package uief_pkg;

  localparam int unsigned ADDRESS_SLOTS = 16;
  localparam int unsigned SLOT_IDX_W    = (ADDRESS_SLOTS > 1) ? $clog2(ADDRESS_SLOTS) : 1;
  localparam int unsigned SLOT_CNT_W    = $clog2(ADDRESS_SLOTS + 1);

  localparam int unsigned CMD_W     = 3;
  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned PORT_W    = 8;
  localparam int unsigned NETID_W   = 7;
  localparam int unsigned NETID_LSB = 25;
  localparam int unsigned MODE_W    = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned PORTS     = 1 << PORT_W;
  localparam int unsigned NETIDS    = 1 << NETID_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_CHECK     = 3'd0,
    CMD_WR_PORT   = 3'd1,
    CMD_WR_ADDR   = 3'd2,
    CMD_WR_NETID  = 3'd3,
    CMD_CLEAR_ALL = 3'd4
  } cmd_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_NONE    = 2'd0,
    MODE_INCLUDE = 2'd1,
    MODE_EXCLUDE = 2'd2
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PORT_MODE    = 2'd0,
    REG_ADDRESS_MODE = 2'd1,
    REG_NETID_MODE   = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCAN,
    ST_CLEAR,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic start;
    logic remove;
    logic commit;
    logic clear;
  } addr_ctl_t;

  typedef struct packed {
    logic done;
    logic hit;
    logic full;
  } addr_sts_t;

  function automatic logic set_drops(logic [MODE_W-1:0] mode, logic member);
    logic res;
    case (mode)
      MODE_INCLUDE: res = member;
      MODE_EXCLUDE: res = !member;
      default:      res = 1'b0;
    endcase
    return res;
  endfunction

endpackage

// ----- hdl/uplink_include_exclude_filter.sv -----
// Uplink include/exclude filter: top level with command sequencer, port and
// network id set RAMs, mode registers and result register.
// Depends on uief_pkg, uief_ram, uief_addr_store and the assertion macro header.
//
// Usage:
//   in_valid_i/in_ready_o take one command beat: check a packet, write a port,
//   address or network id entry, or clear all sets. out_valid_o/out_ready_i
//   return one beat per command: drop for checks, status = 1 when an address
//   add finds the store full. Modes are written on cfg_we_i; the user must
//   write them only while idle, the block itself does not enforce it.
//   Checks and address writes scan the store one entry per cycle; clear all
//   wipes the port and network id RAMs one entry per cycle; other commands
//   go straight to the final step. One command is in flight at a time, so
//   the next beat is taken once the result loads and the sequencer is idle.
//   The result register lets a new command start while the previous result
//   waits; a stalled receiver only holds the sequencer at its last step.
//   Reset empties the address set, sets every mode to none and wipes the
//   port and network id RAMs with in_ready_o low.
`include "uplink_include_exclude_filter_macros.svh"

module uplink_include_exclude_filter (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [uief_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [uief_pkg::MODE_W-1:0]      cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [uief_pkg::CMD_W-1:0]       cmd_i,
  input  logic [uief_pkg::ADDR_W-1:0]      dev_address_i,
  input  logic [uief_pkg::PORT_W-1:0]      frame_port_i,
  input  logic [uief_pkg::NETID_W-1:0]     network_id_i,
  input  logic                             present_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             drop_o,
  output logic                             status_o
);

  uief_pkg::state_e                  state_q, state_d;
  logic [uief_pkg::MODE_W-1:0]       port_mode_q, address_mode_q, netid_mode_q;
  logic [uief_pkg::CMD_W-1:0]        cmd_q;
  logic [uief_pkg::ADDR_W-1:0]       addr_q;
  logic [uief_pkg::PORT_W-1:0]       port_q;
  logic [uief_pkg::NETID_W-1:0]      nid_q;
  logic                              present_q;
  logic [uief_pkg::PORT_W-1:0]       clr_q, clr_d;
  logic                              out_valid_q;
  logic                              drop_q, drop_d;
  logic                              status_q, status_d;

  uief_pkg::addr_ctl_t               addr_ctl;
  uief_pkg::addr_sts_t               addr_sts;
  logic                              accept;
  logic                              out_free;
  logic                              load;
  logic                              port_hit;
  logic                              netid_hit;
  logic                              port_we;
  logic [uief_pkg::PORT_W-1:0]       port_waddr;
  logic                              port_wdata;
  logic                              netid_we;
  logic [uief_pkg::NETID_W-1:0]      netid_waddr;
  logic                              netid_wdata;

  uief_addr_store u_addr_store (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctl_i (addr_ctl),
    .key_i (addr_q),
    .sts_o (addr_sts)
  );

  uief_ram #(
    .WIDTH(1),
    .DEPTH(uief_pkg::PORTS)
  ) u_port_ram (
    .clk_i  (clk_i),
    .we_i   (port_we),
    .waddr_i(port_waddr),
    .wdata_i(port_wdata),
    .raddr_i(port_q),
    .rdata_o(port_hit)
  );

  uief_ram #(
    .WIDTH(1),
    .DEPTH(uief_pkg::NETIDS)
  ) u_netid_ram (
    .clk_i  (clk_i),
    .we_i   (netid_we),
    .waddr_i(netid_waddr),
    .wdata_i(netid_wdata),
    .raddr_i(addr_q[uief_pkg::NETID_LSB +: uief_pkg::NETID_W]),
    .rdata_o(netid_hit)
  );

  assign in_ready_o = (state_q == uief_pkg::ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    drop_d = (cmd_q == uief_pkg::CMD_CHECK) &&
             (uief_pkg::set_drops(port_mode_q, port_hit) ||
              uief_pkg::set_drops(address_mode_q, addr_sts.hit) ||
              uief_pkg::set_drops(netid_mode_q, netid_hit));
    status_d = (cmd_q == uief_pkg::CMD_WR_ADDR) && present_q &&
               !addr_sts.hit && addr_sts.full;
  end

  always_comb begin
    state_d         = state_q;
    clr_d           = '0;
    addr_ctl        = '0;
    addr_ctl.remove = (cmd_q == uief_pkg::CMD_WR_ADDR) && !present_q;
    load            = 1'b0;
    port_we         = 1'b0;
    port_waddr      = port_q;
    port_wdata      = present_q;
    netid_we        = 1'b0;
    netid_waddr     = nid_q;
    netid_wdata     = present_q;
    case (state_q)
      uief_pkg::ST_INIT, uief_pkg::ST_CLEAR: begin
        // wipe both set RAMs, one entry per cycle
        port_we     = 1'b1;
        port_waddr  = clr_q;
        port_wdata  = 1'b0;
        netid_we    = 1'b1;
        netid_waddr = clr_q[uief_pkg::NETID_W-1:0];
        netid_wdata = 1'b0;
        clr_d       = uief_pkg::PORT_W'(clr_q + 1'b1);
        if (clr_q == uief_pkg::PORT_W'(uief_pkg::PORTS - 1)) begin
          state_d = (state_q == uief_pkg::ST_INIT) ? uief_pkg::ST_IDLE : uief_pkg::ST_DONE;
        end
      end
      uief_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          addr_ctl.start = cmd_i inside {uief_pkg::CMD_CHECK, uief_pkg::CMD_WR_ADDR};
          if (addr_ctl.start) begin
            state_d = uief_pkg::ST_SCAN;
          end else if (cmd_i == uief_pkg::CMD_CLEAR_ALL) begin
            state_d = uief_pkg::ST_CLEAR;
          end else begin
            state_d = uief_pkg::ST_DONE;
          end
        end
      end
      uief_pkg::ST_SCAN: begin
        if (addr_sts.done) begin
          state_d = uief_pkg::ST_DONE;
        end
      end
      uief_pkg::ST_DONE: begin
        if (out_free) begin
          load            = 1'b1;
          state_d         = uief_pkg::ST_IDLE;
          addr_ctl.commit = (cmd_q == uief_pkg::CMD_WR_ADDR) && present_q;
          addr_ctl.clear  = (cmd_q == uief_pkg::CMD_CLEAR_ALL);
          port_we         = (cmd_q == uief_pkg::CMD_WR_PORT);
          netid_we        = (cmd_q == uief_pkg::CMD_WR_NETID);
        end
      end
      default: state_d = uief_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= uief_pkg::ST_INIT;
      clr_q          <= '0;
      port_mode_q    <= uief_pkg::MODE_NONE;
      address_mode_q <= uief_pkg::MODE_NONE;
      netid_mode_q   <= uief_pkg::MODE_NONE;
      out_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          uief_pkg::REG_PORT_MODE:    port_mode_q    <= cfg_wdata_i;
          uief_pkg::REG_ADDRESS_MODE: address_mode_q <= cfg_wdata_i;
          uief_pkg::REG_NETID_MODE:   netid_mode_q   <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q     <= cmd_i;
      addr_q    <= dev_address_i;
      port_q    <= frame_port_i;
      nid_q     <= network_id_i;
      present_q <= present_i;
    end
    if (load) begin
      drop_q   <= drop_d;
      status_q <= status_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign drop_o      = drop_q;
  assign status_o    = status_q;

  `UIEF_ASSERT(a_check_scans, clk_i, rst_ni,
    (accept && (cmd_i == uief_pkg::CMD_CHECK)) |=> (state_q == uief_pkg::ST_SCAN),
    "check beat did not start an address scan")
  `UIEF_ASSERT(a_result_from_done, clk_i, rst_ni,
    $rose(out_valid_q) |-> ($past(state_q) == uief_pkg::ST_DONE),
    "result loaded outside the final step")
  `UIEF_ASSERT(a_status_only_addr_add, clk_i, rst_ni,
    (load && status_d) |-> ((cmd_q == uief_pkg::CMD_WR_ADDR) && present_q),
    "full status on a command other than address add")
  `UIEF_ASSERT(a_drop_only_check, clk_i, rst_ni,
    (load && drop_d) |-> (cmd_q == uief_pkg::CMD_CHECK),
    "drop raised on a write command")

endmodule

// ----- hdl/uief_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependencies.
module uief_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/uief_addr_store.sv -----
// Device address set: entry RAM, valid bits and a one-entry-per-cycle scan.
// Depends on uief_pkg, uief_ram and the assertion macro header.
`include "uplink_include_exclude_filter_macros.svh"

module uief_addr_store (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  uief_pkg::addr_ctl_t              ctl_i,
  input  logic [uief_pkg::ADDR_W-1:0]      key_i,
  output uief_pkg::addr_sts_t              sts_o
);

  logic                                active_q, active_d;
  logic [uief_pkg::SLOT_CNT_W-1:0]     idx_q, idx_d;
  logic                                cmp_ok_q, cmp_ok_d;
  logic [uief_pkg::SLOT_IDX_W-1:0]     cmp_idx_q, cmp_idx_d;
  logic                                hit_q, hit_d;
  logic                                free_ok_q, free_ok_d;
  logic [uief_pkg::SLOT_IDX_W-1:0]     free_idx_q, free_idx_d;
  logic                                done_q, done_d;
  logic [uief_pkg::ADDRESS_SLOTS-1:0]  valid_q, valid_d;

  logic                                issue;
  logic                                slot_live;
  logic                                match;
  logic                                ram_we;
  logic [uief_pkg::ADDR_W-1:0]         ram_rdata;

  uief_ram #(
    .WIDTH(uief_pkg::ADDR_W),
    .DEPTH(uief_pkg::ADDRESS_SLOTS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(free_idx_q),
    .wdata_i(key_i),
    .raddr_i(idx_q[uief_pkg::SLOT_IDX_W-1:0]),
    .rdata_o(ram_rdata)
  );

  assign issue     = active_q && (idx_q != uief_pkg::SLOT_CNT_W'(uief_pkg::ADDRESS_SLOTS));
  assign slot_live = valid_q[cmp_idx_q];
  assign match     = cmp_ok_q && slot_live && (ram_rdata == key_i);
  assign ram_we    = ctl_i.commit && !hit_q && free_ok_q;

  always_comb begin
    active_d   = active_q;
    idx_d      = idx_q;
    cmp_ok_d   = cmp_ok_q;
    cmp_idx_d  = cmp_idx_q;
    hit_d      = hit_q;
    free_ok_d  = free_ok_q;
    free_idx_d = free_idx_q;
    done_d     = done_q;
    valid_d    = valid_q;
    if (ctl_i.start) begin
      active_d  = 1'b1;
      idx_d     = '0;
      cmp_ok_d  = 1'b0;
      hit_d     = 1'b0;
      free_ok_d = 1'b0;
      done_d    = 1'b0;
    end else if (active_q) begin
      idx_d     = issue ? uief_pkg::SLOT_CNT_W'(idx_q + 1'b1) : idx_q;
      cmp_ok_d  = issue;
      cmp_idx_d = idx_q[uief_pkg::SLOT_IDX_W-1:0];
      if (match) begin
        hit_d = 1'b1;
        if (ctl_i.remove) begin
          valid_d[cmp_idx_q] = 1'b0;
        end
      end
      // lowest free slot, for a later add
      if (cmp_ok_q && !slot_live && !free_ok_q) begin
        free_ok_d  = 1'b1;
        free_idx_d = cmp_idx_q;
      end
      if (!issue && !cmp_ok_q) begin
        active_d = 1'b0;
        done_d   = 1'b1;
      end
    end
    if (ctl_i.clear) begin
      valid_d = '0;
    end else if (ram_we) begin
      valid_d[free_idx_q] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      cmp_ok_q  <= 1'b0;
      hit_q     <= 1'b0;
      free_ok_q <= 1'b0;
      done_q    <= 1'b0;
      valid_q   <= '0;
    end else begin
      active_q  <= active_d;
      cmp_ok_q  <= cmp_ok_d;
      hit_q     <= hit_d;
      free_ok_q <= free_ok_d;
      done_q    <= done_d;
      valid_q   <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    cmp_idx_q  <= cmp_idx_d;
    free_idx_q <= free_idx_d;
  end

  assign sts_o.done = done_q;
  assign sts_o.hit  = hit_q;
  assign sts_o.full = !free_ok_q;

  `UIEF_ASSERT_NEVER(a_start_while_busy, clk_i, rst_ni, ctl_i.start && active_q,
    "scan restarted while running")
  `UIEF_ASSERT_NEVER(a_done_and_active, clk_i, rst_ni, done_q && active_q,
    "scan done while still active")
  `UIEF_ASSERT(a_done_after_scan, clk_i, rst_ni, $rose(done_q) |-> $past(active_q),
    "done raised without a scan")

endmodule

// ----- dv/uplink_include_exclude_filter_tb.sv -----
// Self-checking testbench for uplink_include_exclude_filter: drives command beats,
// predicts drop/status from its own copy of the sets and modes, checks every result beat.
// Depends on uief_pkg and the filter RTL only.
module uplink_include_exclude_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import uief_pkg::*;

  localparam int unsigned MAX_GAP       = 16;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned SETTLE_CYCLES = 30;
  localparam int unsigned ADDR_POOL     = 24;
  localparam int unsigned PORT_POOL     = 10;
  localparam int unsigned PHASES        = 12;
  localparam int unsigned PHASE_BEATS   = 100;
  localparam int unsigned REPORT_LIMIT  = 10;
  localparam int unsigned TIMEOUT_NS    = 1_000_000;

  localparam logic [CMD_W-1:0]     CMD_LAST       = '1;
  localparam logic [MODE_W-1:0]    MODE_RESERVED  = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE  = '1;

  typedef struct {
    logic [CMD_W-1:0]   cmd;
    logic [ADDR_W-1:0]  addr;
    logic [PORT_W-1:0]  port;
    logic [NETID_W-1:0] nid;
    logic               present;
  } beat_t;

  typedef struct packed {
    logic drop;
    logic status;
  } verdict_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [MODE_W-1:0]    cfg_wdata;
  logic                 in_valid;
  logic                 in_ready_o;
  logic [CMD_W-1:0]     cmd;
  logic [ADDR_W-1:0]    dev_address;
  logic [PORT_W-1:0]    frame_port;
  logic [NETID_W-1:0]   network_id;
  logic                 present;
  logic                 out_valid_o;
  logic                 out_ready;
  logic                 drop_o;
  logic                 status_o;

  logic        hold_req = 1'b0;
  bit          tx_idle_on = 1'b1;
  bit          rx_idle_on = 1'b1;
  int unsigned fail_count = 0;

  verdict_t verdict_q[$];

  // filter state as predicted
  logic [MODE_W-1:0] port_mode_q = MODE_NONE;
  logic [MODE_W-1:0] addr_mode_q = MODE_NONE;
  logic [MODE_W-1:0] netid_mode_q = MODE_NONE;
  bit                port_set[PORTS];
  bit                netid_set[NETIDS];
  logic [ADDR_W-1:0] addr_slot[ADDRESS_SLOTS];
  bit                addr_used[ADDRESS_SLOTS];

  logic [ADDR_W-1:0] addr_pool[ADDR_POOL];
  logic [PORT_W-1:0] port_pool[PORT_POOL];

  uplink_include_exclude_filter dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready_o),
    .cmd_i         (cmd),
    .dev_address_i (dev_address),
    .frame_port_i  (frame_port),
    .network_id_i  (network_id),
    .present_i     (present),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready),
    .drop_o        (drop_o),
    .status_o      (status_o)
  );

  always #1 clk = ~clk;

  function automatic logic [PORT_W-1:0] rand_port();
    return PORT_W'($urandom);
  endfunction

  function automatic logic [NETID_W-1:0] rand_nid();
    return NETID_W'($urandom);
  endfunction

  function automatic logic rand_bit();
    return 1'($urandom);
  endfunction

  function automatic logic mode_rejects(logic [MODE_W-1:0] mode, logic member);
    if (mode == MODE_INCLUDE) return member;
    if (mode == MODE_EXCLUDE) return !member;
    return 1'b0;
  endfunction

  function automatic int find_slot(logic [ADDR_W-1:0] addr);
    for (int i = 0; i < ADDRESS_SLOTS; i++)
      if (addr_used[i] && addr_slot[i] == addr) return i;
    return -1;
  endfunction

  function automatic verdict_t filter_verdict(beat_t b);
    verdict_t v;
    int slot;
    v = '0;
    case (b.cmd)
      CMD_CHECK: begin
        v.drop = mode_rejects(port_mode_q, port_set[b.port])
               | mode_rejects(addr_mode_q, find_slot(b.addr) >= 0)
               | mode_rejects(netid_mode_q, netid_set[b.addr[NETID_LSB +: NETID_W]]);
      end
      CMD_WR_PORT: port_set[b.port] = b.present;
      CMD_WR_ADDR: begin
        slot = find_slot(b.addr);
        if (b.present) begin
          if (slot < 0) begin
            for (int i = 0; i < ADDRESS_SLOTS; i++)
              if (!addr_used[i] && slot < 0) slot = i;
            if (slot < 0) begin
              v.status = 1'b1;
            end else begin
              addr_slot[slot] = b.addr;
              addr_used[slot] = 1'b1;
            end
          end
        end else if (slot >= 0) begin
          addr_used[slot] = 1'b0;
        end
      end
      CMD_WR_NETID: netid_set[b.nid] = b.present;
      CMD_CLEAR_ALL: begin
        port_set = '{default: 1'b0};
        netid_set = '{default: 1'b0};
        addr_used = '{default: 1'b0};
      end
      default: ;
    endcase
    return v;
  endfunction

  function automatic beat_t make_beat(logic [CMD_W-1:0] c, logic [ADDR_W-1:0] a,
                                      logic [PORT_W-1:0] p, logic [NETID_W-1:0] n,
                                      logic pr);
    beat_t b;
    b.cmd = c;
    b.addr = a;
    b.port = p;
    b.nid = n;
    b.present = pr;
    return b;
  endfunction

  function automatic beat_t random_beat();
    beat_t b;
    int unsigned pick;
    b = make_beat(CMD_CHECK, $urandom, rand_port(), rand_nid(), rand_bit());
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      b.cmd = CMD_CHECK;
    end else if (pick < 52) begin
      b.cmd = CMD_WR_PORT;
    end else if (pick < 82) begin
      b.cmd = CMD_WR_ADDR;
      b.present = ($urandom_range(0, 3) != 0);
    end else if (pick < 94) begin
      b.cmd = CMD_WR_NETID;
    end else if (pick < 95) begin
      b.cmd = CMD_CLEAR_ALL;
    end else begin
      b.cmd = CMD_W'($urandom_range(CMD_CLEAR_ALL + 1, CMD_LAST));
    end
    if ($urandom_range(0, 9) < 8) b.addr = addr_pool[$urandom_range(0, ADDR_POOL - 1)];
    if ($urandom_range(0, 9) < 7) b.port = port_pool[$urandom_range(0, PORT_POOL - 1)];
    if ($urandom_range(0, 9) < 7)
      b.nid = addr_pool[$urandom_range(0, ADDR_POOL - 1)][NETID_LSB +: NETID_W];
    return b;
  endfunction

  task automatic note_failure(string msg);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  task automatic send_beat(beat_t b);
    int unsigned gap;
    gap = tx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    cmd         <= b.cmd;
    dev_address <= b.addr;
    frame_port  <= b.port;
    network_id  <= b.nid;
    present     <= b.present;
    do @(posedge clk); while (in_ready_o !== 1'b1);
    verdict_q.push_back(filter_verdict(b));
  endtask

  task automatic drain_and_settle();
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // only call with the block idle
  task automatic write_modes(logic [MODE_W-1:0] pm, logic [MODE_W-1:0] am,
                             logic [MODE_W-1:0] nm, bit poke_spare);
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_PORT_MODE;
    cfg_wdata <= pm;
    @(posedge clk);
    port_mode_q = pm;
    cfg_idx   <= REG_ADDRESS_MODE;
    cfg_wdata <= am;
    @(posedge clk);
    addr_mode_q = am;
    cfg_idx   <= REG_NETID_MODE;
    cfg_wdata <= nm;
    @(posedge clk);
    netid_mode_q = nm;
    if (poke_spare) begin
      cfg_idx   <= CFG_IDX_SPARE;
      cfg_wdata <= MODE_W'($urandom);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic test_unused_commands();
    send_beat(make_beat(CMD_W'(CMD_CLEAR_ALL + 1), '1, '1, '1, 1'b1));
    send_beat(make_beat(CMD_LAST, $urandom, rand_port(), rand_nid(), rand_bit()));
    send_beat(make_beat(CMD_CHECK, '1, '1, '1, 1'b1));
    send_beat(make_beat(CMD_CHECK, '0, '0, '0, 1'b0));
  endtask

  task automatic test_port_set();
    drain_and_settle();
    write_modes(MODE_INCLUDE, MODE_NONE, MODE_NONE, 1'b0);
    send_beat(make_beat(CMD_WR_PORT, $urandom, '1, rand_nid(), 1'b1));
    send_beat(make_beat(CMD_CHECK, $urandom, '1, rand_nid(), rand_bit()));
    send_beat(make_beat(CMD_CHECK, $urandom, '0, rand_nid(), rand_bit()));
    drain_and_settle();
    write_modes(MODE_EXCLUDE, MODE_NONE, MODE_NONE, 1'b0);
    send_beat(make_beat(CMD_CHECK, $urandom, '0, rand_nid(), rand_bit()));
    send_beat(make_beat(CMD_WR_PORT, $urandom, '1, rand_nid(), 1'b0));
  endtask

  task automatic test_netid_set();
    drain_and_settle();
    write_modes(MODE_NONE, MODE_NONE, MODE_INCLUDE, 1'b0);
    send_beat(make_beat(CMD_WR_NETID, $urandom, rand_port(), '1, 1'b1));
    send_beat(make_beat(CMD_CHECK, 32'hFE00_0000, rand_port(), '0, rand_bit()));
    drain_and_settle();
    write_modes(MODE_RESERVED, MODE_RESERVED, MODE_RESERVED, 1'b1);
    send_beat(make_beat(CMD_CHECK, 32'hFE00_0000, rand_port(), rand_nid(), rand_bit()));
  endtask

  task automatic test_clear_all();
    drain_and_settle();
    write_modes(MODE_NONE, MODE_NONE, MODE_EXCLUDE, 1'b0);
    send_beat(make_beat(CMD_CLEAR_ALL, $urandom, rand_port(), rand_nid(), rand_bit()));
    send_beat(make_beat(CMD_CHECK, 32'hFE00_0000, rand_port(), rand_nid(), rand_bit()));
  endtask

  task automatic test_address_store();
    drain_and_settle();
    write_modes(MODE_NONE, MODE_EXCLUDE, MODE_NONE, 1'b0);
    send_beat(make_beat(CMD_WR_ADDR, '0, rand_port(), rand_nid(), 1'b1));
    send_beat(make_beat(CMD_WR_ADDR, '1, rand_port(), rand_nid(), 1'b1));
    // distinct low nibbles keep the fill free of duplicates
    for (int i = 1; i < ADDRESS_SLOTS - 1; i++)
      send_beat(make_beat(CMD_WR_ADDR, ($urandom & ~32'hF) | i, rand_port(), rand_nid(),
                          1'b1));
    send_beat(make_beat(CMD_WR_ADDR, '0, rand_port(), rand_nid(), 1'b1));
    send_beat(make_beat(CMD_WR_ADDR, $urandom, rand_port(), rand_nid(), 1'b1));
    send_beat(make_beat(CMD_WR_ADDR, $urandom, rand_port(), rand_nid(), 1'b0));
    send_beat(make_beat(CMD_CHECK, '1, rand_port(), rand_nid(), rand_bit()));
  endtask

  task automatic test_backpressure();
    drain_and_settle();
    tx_idle_on = 1'b0;
    hold_req <= 1'b1;
    repeat (40) send_beat(random_beat());
    drain_and_settle();
    repeat (20) send_beat(random_beat());
    tx_idle_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    for (int i = 0; i < ADDR_POOL; i++) addr_pool[i] = $urandom;
    addr_pool[0] = '0;
    addr_pool[1] = '1;
    for (int i = 0; i < PORT_POOL; i++) port_pool[i] = PORT_W'($urandom);
    port_pool[0] = '0;
    port_pool[1] = '1;
    for (int ph = 0; ph < PHASES; ph++) begin
      drain_and_settle();
      write_modes(MODE_W'($urandom_range(0, 3)), MODE_W'($urandom_range(0, 3)),
                  MODE_W'($urandom_range(0, 3)), $urandom_range(0, 3) == 0);
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      repeat (PHASE_BEATS) send_beat(random_beat());
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  always @(posedge clk) begin : result_check
    verdict_t want;
    if (rst_n === 1'b1 && out_valid_o === 1'b1 && out_ready === 1'b1) begin
      if (verdict_q.size() == 0) begin
        note_failure($sformatf("unexpected result beat: drop=%b status=%b",
                               drop_o, status_o));
      end else begin
        want = verdict_q.pop_front();
        if (drop_o !== want.drop)
          note_failure($sformatf("drop mismatch: expected %b, got %b", want.drop, drop_o));
        if (status_o !== want.status)
          note_failure($sformatf("status mismatch: expected %b, got %b",
                                 want.status, status_o));
      end
    end
  end

  initial begin : result_sink
    int unsigned stall;
    bit          held;
    held = 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (hold_req && !held) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        stall = rx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
        if (stall != 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid_o !== 1'b1 && !(hold_req && !held));
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    rst_n       <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_idx     <= REG_PORT_MODE;
    cfg_wdata   <= MODE_NONE;
    in_valid    <= 1'b0;
    cmd         <= CMD_CHECK;
    dev_address <= '0;
    frame_port  <= '0;
    network_id  <= '0;
    present     <= 1'b0;
    out_ready   <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_unused_commands();
    test_port_set();
    test_netid_set();
    test_clear_all();
    test_address_store();
    test_backpressure();
    test_random_traffic();

    drain_and_settle();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
